@@ rtl/egp_pkg.sv @@
// Shared types, register indexes, reset values and helpers for the glow band pixel generator.
// Used by the top level edge_glow_gradient_pixel; depends on nothing else.
package egp_pkg;

    localparam int MAX_THICKNESS = 255;
    localparam int MAX_LENGTH    = 4095;

    // Quotient width of every divider in the pipeline.
    localparam int QUO_W = 8;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 12;

    localparam logic [CFG_IDX_W-1:0] CFG_GLOW_RED         = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GLOW_GREEN       = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GLOW_BLUE        = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_EDGE_DIRECTION   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_BAND_THICKNESS   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_BAND_LENGTH      = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_RAMP_NUMERATOR   = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_RAMP_DENOMINATOR = 3'd7;

    localparam logic [7:0]  RST_GLOW_RED         = 8'd127;
    localparam logic [7:0]  RST_GLOW_GREEN       = 8'd255;
    localparam logic [7:0]  RST_GLOW_BLUE        = 8'd60;
    localparam logic [1:0]  RST_EDGE_DIRECTION   = 2'd0;
    localparam logic [7:0]  RST_BAND_THICKNESS   = 8'd9;
    localparam logic [11:0] RST_BAND_LENGTH      = 12'd100;
    localparam logic [7:0]  RST_RAMP_NUMERATOR   = 8'd3;
    localparam logic [7:0]  RST_RAMP_DENOMINATOR = 8'd5;

    localparam logic [1:0] DIR_TOP    = 2'd0;
    localparam logic [1:0] DIR_RIGHT  = 2'd1;
    localparam logic [1:0] DIR_BOTTOM = 2'd2;
    localparam logic [1:0] DIR_LEFT   = 2'd3;

    typedef struct packed {
        logic [7:0]  row_index;
        logic [11:0] column_index;
    } in_item_t;

    typedef struct packed {
        logic [7:0]  pixel_red;
        logic [7:0]  pixel_green;
        logic [7:0]  pixel_blue;
        logic [7:0]  pixel_alpha;
        logic [19:0] pixel_address;
        logic        out_of_range;
    } out_item_t;

    // Exact x/255 for x up to 255*255, by reciprocal with a rounding term.
    function automatic logic [7:0] div255(input logic [15:0] x);
        logic [16:0] s;
        begin
            s = {1'b0, x} + {9'd0, x[15:8]} + 17'd1;
            div255 = s[15:8];
        end
    endfunction

endpackage

@@ rtl/edge_glow_gradient_pixel.sv @@
// Top level of the glow band pixel generator: registers, operand stage, two divider banks, output.
// Depends on egp_pkg, egp_divider and egp_delay.
//
//  Channel  | Handshake            | Payload
//  ---------+----------------------+----------------------------
//  input    | start, busy          | item   (egp_pkg::in_item_t)
//  result   | done (one cycle)     | result (egp_pkg::out_item_t)
//  config   | cfg_we               | cfg_index, cfg_data
//
// One transaction enters per clock; busy is always low. Each result appears with done
// after its transaction passes the operand stage, which the taking edge loads,
// then eight divider stages for the ramp and fade, a product stage, eight divider
// stages for the side taper and the output register.
// Reset clears the valid bits and loads the register reset values.
// The result side takes every result as it comes, so nothing ever waits.
module edge_glow_gradient_pixel (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  start,
    output logic                                  busy,
    input  egp_pkg::in_item_t                     item,
    output logic                                  done,
    output egp_pkg::out_item_t                    result,
    input  logic                                  cfg_we,
    input  logic [egp_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [egp_pkg::CFG_DATA_W-1:0]        cfg_data
);

    localparam int QW = egp_pkg::QUO_W;

    logic [7:0]  glow_red_reg, glow_green_reg, glow_blue_reg;
    logic [1:0]  edge_direction_reg;
    logic [7:0]  band_thickness_reg;
    logic [11:0] band_length_reg;
    logic [7:0]  ramp_numerator_reg, ramp_denominator_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            glow_red_reg         <= egp_pkg::RST_GLOW_RED;
            glow_green_reg       <= egp_pkg::RST_GLOW_GREEN;
            glow_blue_reg        <= egp_pkg::RST_GLOW_BLUE;
            edge_direction_reg   <= egp_pkg::RST_EDGE_DIRECTION;
            band_thickness_reg   <= egp_pkg::RST_BAND_THICKNESS;
            band_length_reg      <= egp_pkg::RST_BAND_LENGTH;
            ramp_numerator_reg   <= egp_pkg::RST_RAMP_NUMERATOR;
            ramp_denominator_reg <= egp_pkg::RST_RAMP_DENOMINATOR;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                egp_pkg::CFG_GLOW_RED:         glow_red_reg         <= cfg_data[7:0];
                egp_pkg::CFG_GLOW_GREEN:       glow_green_reg       <= cfg_data[7:0];
                egp_pkg::CFG_GLOW_BLUE:        glow_blue_reg        <= cfg_data[7:0];
                egp_pkg::CFG_EDGE_DIRECTION:   edge_direction_reg   <= cfg_data[1:0];
                egp_pkg::CFG_BAND_THICKNESS:   band_thickness_reg   <= cfg_data[7:0];
                egp_pkg::CFG_BAND_LENGTH:      band_length_reg      <= cfg_data[11:0];
                egp_pkg::CFG_RAMP_NUMERATOR:   ramp_numerator_reg   <= cfg_data[7:0];
                egp_pkg::CFG_RAMP_DENOMINATOR: ramp_denominator_reg <= cfg_data[7:0];
                default: ;
            endcase
        end
    end

    // Effective band geometry and slope.
    logic [7:0]  th;
    logic [11:0] len;
    logic [7:0]  den;
    logic [7:0]  col [0:2];

    always_comb
    begin
        th  = (32'(band_thickness_reg) > egp_pkg::MAX_THICKNESS) ?
              8'(egp_pkg::MAX_THICKNESS) : band_thickness_reg;
        len = (32'(band_length_reg) > egp_pkg::MAX_LENGTH) ?
              12'(egp_pkg::MAX_LENGTH) : band_length_reg;
        den = (ramp_denominator_reg == 8'd0) ? 8'd1 : ramp_denominator_reg;
        col[0] = glow_red_reg;
        col[1] = glow_green_reg;
        col[2] = glow_blue_reg;
    end

    assign busy = 1'b0;

    // Operand stage: products, range check, taper length and address.
    logic [7:0]  y;
    logic [11:0] x;
    logic [15:0] y_num;
    logic [7:0]  y_inv;
    logic [11:0] mul_a, mul_b, addend;
    logic [23:0] addr_prod;
    logic [12:0] x_plus_th;
    logic [7:0]  t_next;
    logic        taper_next;

    always_comb
    begin
        y         = item.row_index;
        x         = item.column_index;
        y_num     = 16'(y) * 16'(ramp_numerator_reg);
        y_inv     = th - 8'd1 - y;
        x_plus_th = 13'(x) + 13'(th);
        if (edge_direction_reg[0])
        begin
            mul_a  = x;
            mul_b  = 12'(th);
            addend = (edge_direction_reg == egp_pkg::DIR_RIGHT) ? 12'(y) : 12'(y_inv);
        end
        else
        begin
            mul_a  = (edge_direction_reg == egp_pkg::DIR_TOP) ? 12'(y_inv) : 12'(y);
            mul_b  = len;
            addend = x;
        end
        addr_prod = 24'(mul_a) * 24'(mul_b);
        t_next     = 8'd0;
        taper_next = 1'b0;
        if (x < 12'(th))
        begin
            t_next     = 8'(x + 12'd1);
            taper_next = edge_direction_reg[0];
        end
        else if (x_plus_th > 13'(len))
        begin
            t_next     = 8'(len - x);
            taper_next = edge_direction_reg[0];
        end
    end

    logic        a_valid_reg;
    logic [23:0] a_nramp_reg;
    logic [15:0] a_dramp_reg;
    logic [15:0] a_nfade_reg [0:2];
    logic [7:0]  a_t_reg;
    logic        a_taper_reg, a_last_reg, a_oor_reg;
    logic [19:0] a_addr_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
        end
        else
        begin
            a_valid_reg <= start;
        end
    end

    always_ff @(posedge clk)
    begin
        a_nramp_reg <= {y_num, 8'd0} - 24'(y_num);
        a_dramp_reg <= 16'(th) * 16'(den);
        for (int i = 0; i < 3; i++)
        begin
            a_nfade_reg[i] <= 16'(8'd255 - col[i]) * 16'(y);
        end
        a_t_reg     <= t_next;
        a_taper_reg <= taper_next;
        a_last_reg  <= (9'(y) + 9'd1) == 9'(th);
        a_oor_reg   <= (y >= th) || (x >= len);
        a_addr_reg  <= 20'(addr_prod + 24'(addend));
    end

    // First divider bank: ramp alpha and the fade quotients.
    logic          b_valid;
    logic [QW-1:0] ramp_q;
    logic [QW-1:0] fade_q [0:2];

    egp_divider #(.NW(24), .DW(16), .QW(QW)) u_div_ramp (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (a_valid_reg),
        .dividend  (a_nramp_reg),
        .divisor   (a_dramp_reg),
        .out_valid (b_valid),
        .quotient  (ramp_q)
    );

    genvar c;
    generate
        for (c = 0; c < 3; c++)
        begin : g_fade
            egp_divider #(.NW(16), .DW(8), .QW(QW)) u_div_fade (
                .clk       (clk),
                .rst_n     (rst_n),
                .in_valid  (a_valid_reg),
                .dividend  (a_nfade_reg[c]),
                .divisor   (th),
                .out_valid (),
                .quotient  (fade_q[c])
            );
        end
    endgenerate

    logic [30:0] side1_in, side1_out;
    logic [7:0]  b_t;
    logic        b_taper, b_last, b_oor;
    logic [19:0] b_addr;

    assign side1_in = {a_t_reg, a_taper_reg, a_last_reg, a_oor_reg, a_addr_reg};

    egp_delay #(.W(31), .DEPTH(QW)) u_side1 (
        .clk  (clk),
        .din  (side1_in),
        .dout (side1_out)
    );

    assign {b_t, b_taper, b_last, b_oor, b_addr} = side1_out;

    // Product stage: taper dividends and the untapered colour products.
    logic        c_valid_reg;
    logic [15:0] c_ntap_a_reg;
    logic [15:0] c_ntap_c_reg [0:2];
    logic [15:0] c_prod_reg   [0:2];
    logic        c_taper_reg, c_last_reg, c_oor_reg;
    logic [19:0] c_addr_reg;
    logic [7:0]  c_a1_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c_valid_reg <= 1'b0;
        end
        else
        begin
            c_valid_reg <= b_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        c_ntap_a_reg <= 16'(ramp_q) * 16'(b_t);
        for (int i = 0; i < 3; i++)
        begin
            // 255 minus the faded colour is the fade quotient itself.
            c_ntap_c_reg[i] <= 16'(fade_q[i]) * 16'(b_t);
            c_prod_reg[i]   <= 16'(8'd255 - fade_q[i]) * 16'(ramp_q);
        end
        c_taper_reg <= b_taper;
        c_last_reg  <= b_last;
        c_oor_reg   <= b_oor;
        c_addr_reg  <= b_addr;
        c_a1_reg    <= ramp_q;
    end

    // Second divider bank: side taper of alpha and colour.
    logic          d_valid;
    logic [QW-1:0] tap_alpha;
    logic [QW-1:0] tap_q [0:2];

    egp_divider #(.NW(16), .DW(8), .QW(QW)) u_div_tap_alpha (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (c_valid_reg),
        .dividend  (c_ntap_a_reg),
        .divisor   (th),
        .out_valid (d_valid),
        .quotient  (tap_alpha)
    );

    generate
        for (c = 0; c < 3; c++)
        begin : g_tap
            egp_divider #(.NW(16), .DW(8), .QW(QW)) u_div_tap_col (
                .clk       (clk),
                .rst_n     (rst_n),
                .in_valid  (c_valid_reg),
                .dividend  (c_ntap_c_reg[c]),
                .divisor   (th),
                .out_valid (),
                .quotient  (tap_q[c])
            );
        end
    endgenerate

    logic [78:0] side2_in, side2_out;
    logic        d_taper, d_last, d_oor;
    logic [19:0] d_addr;
    logic [7:0]  d_a1;
    logic [15:0] d_prod [0:2];

    assign side2_in = {c_taper_reg, c_last_reg, c_oor_reg, c_addr_reg, c_a1_reg,
                       c_prod_reg[0], c_prod_reg[1], c_prod_reg[2]};

    egp_delay #(.W(79), .DEPTH(QW)) u_side2 (
        .clk  (clk),
        .din  (side2_in),
        .dout (side2_out)
    );

    assign {d_taper, d_last, d_oor, d_addr, d_a1, d_prod[0], d_prod[1], d_prod[2]} = side2_out;

    // Output stage: pick the tapered, solid or ramp pixel, or a zeroed out-of-range result.
    egp_pkg::out_item_t res_next;
    logic [7:0]         pix [0:2];
    logic [7:0]         alpha;

    always_comb
    begin
        if (d_taper)
        begin
            alpha = tap_alpha;
            for (int i = 0; i < 3; i++)
            begin
                pix[i] = egp_pkg::div255(16'(8'd255 - tap_q[i]) * 16'(tap_alpha));
            end
        end
        else if (d_last)
        begin
            alpha = 8'd255;
            for (int i = 0; i < 3; i++)
            begin
                pix[i] = col[i];
            end
        end
        else
        begin
            alpha = d_a1;
            for (int i = 0; i < 3; i++)
            begin
                pix[i] = egp_pkg::div255(d_prod[i]);
            end
        end
        res_next.pixel_red     = pix[0];
        res_next.pixel_green   = pix[1];
        res_next.pixel_blue    = pix[2];
        res_next.pixel_alpha   = alpha;
        res_next.pixel_address = d_addr;
        res_next.out_of_range  = 1'b0;
        if (d_oor)
        begin
            res_next = '0;
            res_next.out_of_range = 1'b1;
        end
    end

    logic               done_reg;
    egp_pkg::out_item_t result_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= d_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= res_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

@@ rtl/egp_divider.sv @@
// Pipelined restoring divider, one quotient bit per register stage.
// Depends on egp_pkg only through its instantiation parameters.
module egp_divider #(
    parameter int NW = 24,
    parameter int DW = 16,
    parameter int QW = 8
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    input  logic [NW-1:0] dividend,
    input  logic [DW-1:0] divisor,
    output logic          out_valid,
    output logic [QW-1:0] quotient
);

    localparam int RW = (NW > DW + QW) ? NW : DW + QW;

    logic [RW-1:0] rem_reg  [0:QW];
    logic [DW-1:0] dsr_reg  [0:QW];
    logic [QW-1:0] quo_reg  [0:QW];
    logic          over_reg [0:QW];
    logic          vld_reg  [0:QW];

    // Stage zero is the unregistered input; a quotient that does not fit saturates.
    always_comb
    begin
        rem_reg[0]  = RW'(dividend);
        dsr_reg[0]  = divisor;
        quo_reg[0]  = '0;
        over_reg[0] = RW'(dividend) >= (RW'(divisor) << QW);
        vld_reg[0]  = in_valid;
    end

    genvar k;
    generate
        for (k = 0; k < QW; k++)
        begin : g_stage
            logic [RW-1:0] shifted;
            logic          take;

            assign shifted = RW'(dsr_reg[k]) << (QW - 1 - k);
            assign take    = rem_reg[k] >= shifted;

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    vld_reg[k+1] <= 1'b0;
                end
                else
                begin
                    vld_reg[k+1] <= vld_reg[k];
                end
            end

            always_ff @(posedge clk)
            begin
                rem_reg[k+1]  <= take ? rem_reg[k] - shifted : rem_reg[k];
                dsr_reg[k+1]  <= dsr_reg[k];
                over_reg[k+1] <= over_reg[k];
                quo_reg[k+1]  <= quo_reg[k] | (take ? (QW'(1) << (QW - 1 - k)) : '0);
            end
        end
    endgenerate

    assign out_valid = vld_reg[QW];
    assign quotient  = over_reg[QW] ? '1 : quo_reg[QW];

endmodule

@@ rtl/egp_delay.sv @@
// Fixed-length shift line that carries side data beside the dividers.
// No package dependency.
module egp_delay #(
    parameter int W     = 8,
    parameter int DEPTH = 8
) (
    input  logic         clk,
    input  logic [W-1:0] din,
    output logic [W-1:0] dout
);

    logic [W-1:0] tap_reg [0:DEPTH-1];

    always_ff @(posedge clk)
    begin
        tap_reg[0] <= din;
        for (int i = 1; i < DEPTH; i++)
        begin
            tap_reg[i] <= tap_reg[i-1];
        end
    end

    assign dout = tap_reg[DEPTH-1];

endmodule
